// ===== rtl/adaptive_jitter_buffer_core_assert.svh =====
// assertion helpers for the jitter buffer, all sampled on clk with rst_n low disabling
`ifndef ADAPTIVE_JITTER_BUFFER_CORE_ASSERT_SVH
`define ADAPTIVE_JITTER_BUFFER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define AJB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define AJB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AJB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ajb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_pkg
// Types and constants shared by the adaptive jitter buffer modules.
// ----------------------------------------------------------------------------
package ajb_pkg;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] size;
    logic [15:0] seq;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // input item modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // register map, selected by paddr[2]
  localparam logic CFG_MIN_IDX = 1'b0;
  localparam logic CFG_MAX_IDX = 1'b1;

  localparam logic [7:0]  MIN_RESET     = 8'd2;
  localparam logic [7:0]  MAX_RESET     = 8'd12;
  localparam logic [7:0]  TARGET_RESET  = 8'd4;
  localparam logic [31:0] AVG_RESET     = 32'd20;
  localparam logic [31:0] NOMINAL_GAP   = 32'd20;
  localparam logic [31:0] ADAPT_PERIOD  = 32'd1000;
  localparam logic [31:0] ISQRT_TOP_BIT = 32'h4000_0000;
  // x/5 == (x * DIV5_MAGIC) >> 34 for any 32-bit x
  localparam logic [31:0] DIV5_MAGIC    = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_JIT,
    ST_DONE
  } core_state_t;

  typedef enum logic [2:0] {
    JS_IDLE,
    JS_SQ,
    JS_EMA,
    JS_CHK,
    JS_ROOT,
    JS_DIV,
    JS_CLAMP,
    JS_FIN
  } jit_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] now;
  } jit_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] target;
  } jit_rsp_t;

endpackage

// ===== rtl/ajb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_in_if
// Input channel: push descriptor or pop request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ajb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] arrival_time_ms;
  logic [31:0] payload_handle;
  logic [15:0] payload_size;
  logic [15:0] seq_number;

  modport source (
    output valid, mode, arrival_time_ms, payload_handle, payload_size, seq_number,
    input  ready
  );
  modport sink (
    input  valid, mode, arrival_time_ms, payload_handle, payload_size, seq_number,
    output ready
  );
endinterface

// ===== rtl/ajb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_out_if
// Result channel: one beat per input item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ajb_out_if;
  logic        valid;
  logic        ready;
  logic        pop_valid;
  logic [31:0] out_handle;
  logic [15:0] out_size;
  logic [15:0] out_seq;
  logic        push_accepted;
  logic [7:0]  target_depth_now;
  logic [7:0]  fill_count;

  modport source (
    output valid, pop_valid, out_handle, out_size, out_seq, push_accepted,
           target_depth_now, fill_count,
    input  ready
  );
  modport sink (
    input  valid, pop_valid, out_handle, out_size, out_seq, push_accepted,
           target_depth_now, fill_count,
    output ready
  );
endinterface

// ===== rtl/ajb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ajb_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_isqrt
// Iterative floor square root of a 32-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module ajb_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [15:0] root
);
  import ajb_pkg::*;

  logic        busy_r, busy_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [31:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = value;
      root_nxt = '0;
      bit_nxt  = ISQRT_TOP_BIT;
    end else if (busy_r) begin
      if (bit_r != '0) begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign done = busy_r && (bit_r == '0);
  assign root = root_r[15:0];

endmodule

// ===== rtl/ajb_jitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajb_jitter
// Arrival jitter estimator: deviation EMAs and periodic target level update.
// ----------------------------------------------------------------------------
module ajb_jitter (
  input  logic             clk,
  input  logic             rst_n,
  input  ajb_pkg::jit_req_t req,
  input  logic [7:0]       min_depth,
  input  logic [7:0]       max_depth,
  output ajb_pkg::jit_rsp_t rsp
);
  import ajb_pkg::*;

  jit_state_t  state_r, state_nxt;
  logic [31:0] avg_r, sq_r, prev_arr_r, prev_adapt_r;
  logic [7:0]  target_r;
  logic [31:0] t_r, a_r, ms_r;
  logic [63:0] prod_r;
  logic [31:0] mul_a, mul_b;

  logic [31:0] dev, dev_abs;
  logic [31:0] avg_sum, sq_sum;
  logic        adapt_due;
  logic        root_start, root_done;
  logic [15:0] root;
  logic [17:0] three_s;
  logic [27:0] lvl, lvl_lo, lvl_hi;

  assign dev     = req.now - prev_arr_r - NOMINAL_GAP;
  assign dev_abs = dev[31] ? (32'd0 - dev) : dev;

  // x*15 as (x<<4) - x, everything mod 2^32
  assign avg_sum   = (avg_r << 4) - avg_r + a_r;
  assign sq_sum    = (sq_r << 4) - sq_r + prod_r[31:0];
  assign adapt_due = (t_r - prev_adapt_r) >= ADAPT_PERIOD;

  assign three_s = {1'b0, root, 1'b0} + {2'b00, root};

  // shared multiplier: a*a for the square, then ms/4 * magic for the /20
  always_comb begin
    if (state_r == JS_SQ) begin
      mul_a = a_r;
      mul_b = a_r;
    end else begin
      mul_a = {2'b00, ms_r[31:2]};
      mul_b = DIV5_MAGIC;
    end
  end

  assign lvl    = prod_r[61:34];
  assign lvl_lo = (lvl < 28'(min_depth)) ? 28'(min_depth) : lvl;
  assign lvl_hi = (lvl_lo > 28'(max_depth)) ? 28'(max_depth) : lvl_lo;

  assign root_start = (state_r == JS_CHK) && adapt_due;

  ajb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sq_r),
    .done  (root_done),
    .root  (root)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      JS_IDLE: begin
        if (req.start) begin
          state_nxt = (prev_arr_r != '0) ? JS_SQ : JS_CHK;
        end
      end
      JS_SQ:    state_nxt = JS_EMA;
      JS_EMA:   state_nxt = JS_CHK;
      JS_CHK:   state_nxt = adapt_due ? JS_ROOT : JS_FIN;
      JS_ROOT: begin
        if (root_done) begin
          state_nxt = JS_DIV;
        end
      end
      JS_DIV:   state_nxt = JS_CLAMP;
      JS_CLAMP: state_nxt = JS_FIN;
      JS_FIN:   state_nxt = JS_IDLE;
      default:  state_nxt = JS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= JS_IDLE;
      avg_r        <= AVG_RESET;
      sq_r         <= '0;
      prev_arr_r   <= '0;
      prev_adapt_r <= '0;
      target_r     <= TARGET_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == JS_IDLE && req.start) begin
        prev_arr_r <= req.now;
      end
      if (state_r == JS_EMA) begin
        avg_r <= {4'b0000, avg_sum[31:4]};
        sq_r  <= {4'b0000, sq_sum[31:4]};
      end
      if (root_start) begin
        prev_adapt_r <= t_r;
      end
      if (state_r == JS_CLAMP) begin
        target_r <= lvl_hi[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (state_r == JS_IDLE && req.start) begin
      t_r <= req.now;
      a_r <= dev_abs;
    end
    if (state_r == JS_ROOT && root_done) begin
      ms_r <= avg_r + 32'(three_s[17:1]);
    end
  end

  assign rsp.done   = (state_r == JS_FIN);
  assign rsp.target = target_r;

endmodule

// ===== rtl/adaptive_jitter_buffer_core.sv =====
// pop: the done state loads the result beat once the output register is free, then the next
//   item is taken; push: square, EMA and check, then the 16-step root, divide and clamp when
//   the 1000 ms update is due; square and EMA are skipped while the last arrival time held is zero
// one item is in flight at a time; a new item is taken while the last result waits
// synchronous active-low reset clears pointers, fill count, estimator and registers;
//   ring contents are not cleared and need no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_core
// Descriptor ring with a release level that follows the arrival jitter.
// ----------------------------------------------------------------------------
module adaptive_jitter_buffer_core #(
  parameter int RING_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  ajb_in_if.sink      in_ch,
  ajb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ajb_pkg::*;

  `include "adaptive_jitter_buffer_core_assert.svh"

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  core_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             res_pop_r, res_pop_nxt;
  logic             res_push_r, res_push_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       min_r, max_r;

  logic             in_acc, cfg_wr;
  logic             full, release_ok, out_load;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail, head_inc;
  logic             ram_we, ram_re;
  desc_t            wr_desc, rd_desc;
  jit_req_t         jit_req;
  jit_rsp_t         jit_rsp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_MAX_IDX) ? {24'd0, max_r} : {24'd0, min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
      max_r <= MAX_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_MIN_IDX) begin
        min_r <= pwdata[7:0];
      end else begin
        max_r <= pwdata[7:0];
      end
    end
  end

  // ---------------- ring addressing ----------------
  assign full       = (cnt_r == CNT_W'(RING_DEPTH));
  assign release_ok = (cnt_r != '0) && (32'(cnt_r) > 32'(jit_rsp.target));
  // head and count both below depth on a push, so one subtract wraps
  assign tail_sum   = {1'b0, head_r} + (IDX_W + 1)'(cnt_r);
  assign tail       = (tail_sum >= (IDX_W + 1)'(RING_DEPTH))
                      ? IDX_W'(tail_sum - (IDX_W + 1)'(RING_DEPTH))
                      : tail_sum[IDX_W-1:0];
  assign head_inc   = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign wr_desc.handle = in_ch.payload_handle;
  assign wr_desc.size   = in_ch.payload_size;
  assign wr_desc.seq    = in_ch.seq_number;

  ajb_ram #(
    .WIDTH (DESC_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (wr_desc),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (rd_desc)
  );

  assign jit_req.start = in_acc && (in_ch.mode == MODE_PUSH) && !full;
  assign jit_req.now   = in_ch.arrival_time_ms;

  ajb_jitter u_jitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (jit_req),
    .min_depth (min_r),
    .max_depth (max_r),
    .rsp       (jit_rsp)
  );

  // ---------------- control ----------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    res_pop_nxt  = res_pop_r;
    res_push_nxt = res_push_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_POP) begin
            res_push_nxt = 1'b0;
            res_pop_nxt  = release_ok;
            if (release_ok) begin
              ram_re   = 1'b1;
              head_nxt = head_inc;
              cnt_nxt  = cnt_r - 1'b1;
            end
            state_nxt = ST_DONE;
          end else begin
            res_pop_nxt  = 1'b0;
            res_push_nxt = !full;
            if (full) begin
              state_nxt = ST_DONE;
            end else begin
              ram_we    = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = ST_JIT;
            end
          end
        end
      end
      ST_JIT: begin
        if (jit_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      res_pop_r   <= 1'b0;
      res_push_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      res_pop_r   <= res_pop_nxt;
      res_push_r  <= res_push_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.pop_valid        <= res_pop_r;
      out_ch.out_handle       <= res_pop_r ? rd_desc.handle : 32'd0;
      out_ch.out_size         <= res_pop_r ? rd_desc.size : 16'd0;
      out_ch.out_seq          <= res_pop_r ? rd_desc.seq : 16'd0;
      out_ch.push_accepted    <= res_push_r;
      out_ch.target_depth_now <= jit_rsp.target;
      out_ch.fill_count       <= 8'(cnt_r);
    end
  end

  assign out_ch.valid = out_valid_r;

  // ---------------- assertions ----------------
  `AJB_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(RING_DEPTH), "fill count beyond ring depth")
  `AJB_ASSERT_IMPL(a_pop_xor_push, out_ch.valid, !(out_ch.pop_valid && out_ch.push_accepted), "beat both released and stored")
  `AJB_ASSERT_NEXT(a_pop_dec, rst_n && in_acc && in_ch.mode == MODE_POP && release_ok, cnt_r == $past(cnt_r) - 1'b1, "release did not lower fill count")
  `AJB_ASSERT_NEXT(a_push_inc, rst_n && in_acc && in_ch.mode == MODE_PUSH && !full, cnt_r == $past(cnt_r) + 1'b1, "stored push did not raise fill count")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the adaptive jitter buffer against an in-bench model of the ring,
// the jitter estimate and the release level. A directed opening covers
// extreme descriptors, timestamp wrap and the release rules. Random phases
// follow, each under its own clamp pair: steady streams, ring fills, bursty
// arrivals and drains. Idle bursts fall on both channels, with one long
// result stall.
// ----------------------------------------------------------------------------
module testbench;
  import ajb_pkg::*;

  localparam int RING         = 128;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 30;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic        mode;
    logic [31:0] arrival;
    logic [31:0] handle;
    logic [15:0] size;
    logic [15:0] seq;
  } request_t;

  typedef struct packed {
    logic        pop_valid;
    logic [31:0] handle;
    logic [15:0] size;
    logic [15:0] seq;
    logic        push_accepted;
    logic [7:0]  target;
    logic [7:0]  fill;
  } release_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ajb_in_if  in_ch ();
  ajb_out_if out_ch ();

  adaptive_jitter_buffer_core #(
    .RING_DEPTH(RING)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  desc_t       ring_store [RING];
  logic [6:0]  m_head;
  int unsigned m_held;
  logic [7:0]  m_target;
  logic [31:0] m_avg;
  logic [31:0] m_sq;
  logic [31:0] m_prev_arrival;
  logic [31:0] m_prev_adapt;
  logic [7:0]  cfg_min;
  logic [7:0]  cfg_max;

  request_t pending_items [$];
  release_t awaited_releases [$];
  request_t in_flight;

  int          errors = 0;
  int          cycle_count = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;
  logic        rx_hold = 1'b0;
  logic [31:0] clock_ms;
  logic [15:0] seq_ctr;

  function automatic logic [31:0] root_floor(input logic [31:0] v);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] bitv;
    rem = v;
    root = '0;
    bitv = ISQRT_TOP_BIT;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic release_t buffer_step(input request_t rq);
    release_t    r;
    logic [31:0] dev;
    logic [31:0] mag;
    logic [31:0] acc;
    logic [31:0] since;
    logic [31:0] spread;
    logic [31:0] lvl;
    r = '0;
    if (rq.mode == MODE_PUSH) begin
      if (m_held < RING) begin
        if (m_prev_arrival != 0) begin
          dev = rq.arrival - m_prev_arrival - NOMINAL_GAP;
          mag = dev[31] ? (32'd0 - dev) : dev;
          acc = m_avg * 32'd15 + mag;
          m_avg = acc >> 4;
          acc = m_sq * 32'd15 + mag * mag;
          m_sq = acc >> 4;
        end
        m_prev_arrival = rq.arrival;
        since = rq.arrival - m_prev_adapt;
        if (since >= ADAPT_PERIOD) begin
          spread = m_avg + (root_floor(m_sq) * 32'd3) / 32'd2;
          lvl = spread / 32'd20;
          if (lvl < {24'd0, cfg_min}) lvl = {24'd0, cfg_min};
          if (lvl > {24'd0, cfg_max}) lvl = {24'd0, cfg_max};
          m_prev_adapt = rq.arrival;
          m_target = lvl[7:0];
        end
        ring_store[(m_head + m_held) % RING] = '{handle: rq.handle, size: rq.size,
                                                 seq: rq.seq};
        m_held++;
        r.push_accepted = 1'b1;
      end
    end else if (m_held != 0 && m_held > m_target) begin
      r.pop_valid = 1'b1;
      r.handle = ring_store[m_head].handle;
      r.size = ring_store[m_head].size;
      r.seq = ring_store[m_head].seq;
      m_head = m_head + 7'd1;
      m_held--;
    end
    r.target = m_target;
    r.fill = m_held[7:0];
    return r;
  endfunction

  task automatic add_push(input logic [31:0] at, input logic [31:0] h,
                          input logic [15:0] sz, input logic [15:0] sq);
    pending_items.push_back('{mode: MODE_PUSH, arrival: at, handle: h, size: sz, seq: sq});
  endtask

  // pop beats carry random payload bits that the block ignores
  task automatic add_pop();
    pending_items.push_back('{mode: MODE_POP, arrival: $urandom(), handle: $urandom(),
                              size: 16'($urandom_range(0, 65535)),
                              seq: 16'($urandom_range(0, 65535))});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || awaited_releases.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_MIN_IDX) cfg_min = value;
    else cfg_max = value;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_releases.push_back(buffer_step(in_flight));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(0, 6);
          in_ch.valid <= 1'b0;
        end else begin
          in_flight = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= in_flight.mode;
          in_ch.arrival_time_ms <= in_flight.arrival;
          in_ch.payload_handle <= in_flight.handle;
          in_ch.payload_size <= in_flight.size;
          in_ch.seq_number <= in_flight.seq;
        end
      end
    end
  end

  // monitor and result-side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_releases.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, got %0h",
                   $time, out_ch.out_handle);
        end else begin
          release_t want;
          want = awaited_releases.pop_front();
          check_field("pop_valid", want.pop_valid, out_ch.pop_valid);
          check_field("out_handle", want.handle, out_ch.out_handle);
          check_field("out_size", want.size, out_ch.out_size);
          check_field("out_seq", want.seq, out_ch.out_seq);
          check_field("push_accepted", want.push_accepted, out_ch.push_accepted);
          check_field("target_depth_now", want.target, out_ch.target_depth_now);
          check_field("fill_count", want.fill, out_ch.fill_count);
        end
      end
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long result stall while the sender keeps offering beats
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int          random_count;
    int          phase;
    int          kind;
    int          length;
    int          push_pct;
    int          jit;
    int          step;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] at;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_PUSH;
    in_ch.arrival_time_ms = '0;
    in_ch.payload_handle = '0;
    in_ch.payload_size = '0;
    in_ch.seq_number = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    m_head = '0;
    m_held = 0;
    m_target = TARGET_RESET;
    m_avg = AVG_RESET;
    m_sq = '0;
    m_prev_arrival = '0;
    m_prev_adapt = '0;
    cfg_min = MIN_RESET;
    cfg_max = MAX_RESET;
    seq_ctr = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening under the reset clamps
    add_pop();                                            // empty ring
    add_push(32'd0, 32'h0000_0000, 16'h0000, 16'h0000);
    // previous arrival still zero, so no jitter update yet
    add_push(32'd20, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_push(32'd40, 32'h1234_5678, 16'd64, 16'd2);
    add_push(32'd1100, 32'hA5A5_5A5A, 16'd1500, 16'd3);   // late beat, adapts
    add_push(32'd1090, 32'h5A5A_A5A5, 16'd160, 16'd4);    // early beat
    at = 32'd1090 + 32'd20 + 32'h8000_0000;               // deviation of exactly 2^31
    add_push(at, 32'h8000_0001, 16'h8000, 16'h8000);
    add_push(32'hFFFF_FFF0, 32'h7FFF_FFFE, 16'h7FFF, 16'h7FFF);
    add_push(32'h0000_0004, 32'hDEAD_0001, 16'd1, 16'd9);  // timestamp wraps
    add_pop();
    add_pop();
    wait_idle();

    // zero clamps take effect at the next adaptation, then drain to empty
    write_reg(CFG_MIN_IDX, 8'd0);
    write_reg(CFG_MAX_IDX, 8'd0);
    add_push(32'd3000, 32'h0F0F_0F0F, 16'd200, 16'd10);
    repeat (10) add_pop();
    wait_idle();

    clock_ms = 32'd3000;
    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      quiet = (RANDOM_ITEMS - random_count <= 200);
      case (phase)
        0: begin lo = 8'd0;   hi = 8'd128; end
        1: begin lo = 8'd128; hi = 8'd128; end
        2: begin lo = 8'd128; hi = 8'd0;   end   // inverted clamps
        3: begin lo = 8'd0;   hi = 8'd0;   end
        default: begin
          lo = 8'($urandom_range(0, 6));
          hi = ($urandom_range(0, 5) == 0) ? 8'd128 : 8'($urandom_range(0, 20));
        end
      endcase
      write_reg(CFG_MIN_IDX, lo);
      write_reg(CFG_MAX_IDX, hi);

      kind = (phase < 4) ? phase : $urandom_range(0, 3);
      case (kind)
        0: begin push_pct = 55; jit = 5;   end   // steady stream
        1: begin push_pct = 92; jit = 15;  end   // fill to full
        2: begin push_pct = 60; jit = 300; end   // bursty arrivals
        default: begin push_pct = 25; jit = 40; end  // drain
      endcase
      if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FC00 + $urandom_range(0, 512);

      length = (kind == 1) ? 150 : $urandom_range(60, 150);
      for (int i = 0; i < length; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          if ($urandom_range(0, 49) == 0) begin
            clock_ms = $urandom();
          end else begin
            step = 20 + int'($urandom_range(0, 2 * jit)) - jit;
            clock_ms = clock_ms + 32'(step);
          end
          if ($urandom_range(0, 19) == 0) seq_ctr = 16'($urandom_range(0, 65535));
          add_push(clock_ms, $urandom(), 16'($urandom_range(0, 65535)), seq_ctr);
          seq_ctr = seq_ctr + 16'd1;
        end else begin
          add_pop();
        end
      end
      random_count += length;
      if (phase == 2) hold_go = 1'b1;
      phase++;
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ajb_pkg.sv
rtl/ajb_in_if.sv
rtl/ajb_out_if.sv
rtl/ajb_ram.sv
rtl/ajb_isqrt.sv
rtl/ajb_jitter.sv
rtl/adaptive_jitter_buffer_core.sv
tb/sv/testbench.sv
